// ===== hw/rtl/dttq_pkg.sv =====
// Shared constants, codes and handshake structs for the deadline timer task queue.
package dttq_pkg;

	// Default sizes of the queue.
	localparam int QueueDepthDef = 64;
	localparam int TaskIdBitsDef = 16;
	localparam int TimeBitsDef   = 48;

	// Fixed field widths of the transaction ports.
	localparam int SeqBits       = 32;
	localparam int TaskFieldBits = 16;
	localparam int DelayBits     = 32;
	localparam int PendingBits   = 7;
	localparam int StatusBits    = 2;

	// Opcodes of an input transaction.
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Result status codes.
	localparam logic [StatusBits-1:0] STATUS_NONE  = 2'd0;
	localparam logic [StatusBits-1:0] STATUS_ADDED = 2'd1;
	localparam logic [StatusBits-1:0] STATUS_FULL  = 2'd2;
	localparam logic [StatusBits-1:0] STATUS_FIRED = 2'd3;

	// Command from the front end to the heap sequencer.
	typedef struct packed {
		logic start;
		logic pop;
	} dttq_cmd_t;

	// Completion report from the heap sequencer.
	typedef struct packed {
		logic done;
		logic fired;
	} dttq_resp_t;

endpackage

// ===== hw/rtl/dttq_heap.sv =====
// Min-heap store and sift sequencer built around one shared key comparator.
module dttq_heap import dttq_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDef,
	parameter int TASK_BITS   = TaskIdBitsDef,
	parameter int TIME_BITS   = TimeBitsDef
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dttq_cmd_t                            cmd,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     cmd_count,
	input  logic [TIME_BITS-1:0]                 new_deadline,
	input  logic [SeqBits-1:0]                   new_seq,
	input  logic [TASK_BITS-1:0]                 new_task,
	input  logic [TIME_BITS-1:0]                 now_time,
	output dttq_resp_t                           resp,
	output logic [TASK_BITS-1:0]                 resp_task
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int IW = AW + 2;
	localparam int KW = TIME_BITS + SeqBits;
	localparam int EW = KW + TASK_BITS;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_UP_CHK   = 4'd1;
	localparam logic [3:0] S_UP_CMP   = 4'd2;
	localparam logic [3:0] S_POP_ROOT = 4'd3;
	localparam logic [3:0] S_POP_LAST = 4'd4;
	localparam logic [3:0] S_DN_L     = 4'd5;
	localparam logic [3:0] S_DN_R     = 4'd6;
	localparam logic [3:0] S_DN_C     = 4'd7;

	logic [3:0]           state_q, state_d;
	logic                 done_q, done_d;
	logic                 fired_q, fired_d;
	logic [AW-1:0]        hole_q, hole_d;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic [EW-1:0]        mv_q, mv_d;
	logic [EW-1:0]        best_q, best_d;
	logic                 best_child_q, best_child_d;
	logic [TIME_BITS-1:0] now_q, now_d;
	logic [TASK_BITS-1:0] task_q, task_d;

	logic [EW-1:0]        mem [QUEUE_DEPTH];
	logic [EW-1:0]        rd_data_q;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [EW-1:0]        wr_data;

	logic [AW-1:0]        hole_m1;
	logic [AW-1:0]        parent;
	logic [IW-1:0]        left_i;
	logic [IW-1:0]        right_i;
	logic [IW-1:0]        cnt_ext;
	logic [CW-1:0]        last_i;
	logic [KW-1:0]        cmp_a;
	logic [KW-1:0]        cmp_b;
	logic                 lt;

	// Heap index arithmetic around the current hole.
	assign hole_m1 = hole_q - AW'(1);
	assign parent  = hole_m1 >> 1;
	assign left_i  = {1'b0, hole_q, 1'b1};
	assign right_i = left_i + IW'(1);
	assign cnt_ext = IW'(cnt_q);
	assign last_i  = cnt_q - CW'(1);

	// Heap storage: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[hole_q] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Read address for the data that the next state will look at.
	always_comb begin
		case (state_q)
			S_UP_CHK:   rd_addr = parent;
			S_POP_ROOT: rd_addr = last_i[AW-1:0];
			S_DN_L:     rd_addr = left_i[AW-1:0];
			S_DN_R:     rd_addr = right_i[AW-1:0];
			default:    rd_addr = '0;
		endcase
	end

	// Shared comparator on {deadline, sequence}; a due check compares the root
	// against the current time with the largest sequence value.
	always_comb begin
		case (state_q)
			S_UP_CMP: begin
				cmp_a = mv_q[EW-1:TASK_BITS];
				cmp_b = rd_data_q[EW-1:TASK_BITS];
			end
			S_POP_ROOT: begin
				cmp_a = {now_q, {SeqBits{1'b1}}};
				cmp_b = rd_data_q[EW-1:TASK_BITS];
			end
			S_DN_R: begin
				cmp_a = rd_data_q[EW-1:TASK_BITS];
				cmp_b = mv_q[EW-1:TASK_BITS];
			end
			S_DN_C: begin
				cmp_a = rd_data_q[EW-1:TASK_BITS];
				cmp_b = best_q[EW-1:TASK_BITS];
			end
			default: begin
				cmp_a = '0;
				cmp_b = '0;
			end
		endcase
	end

	assign lt = cmp_a < cmp_b;

	// Sift sequencer: insert moves a hole up, pop moves a hole down.
	always_comb begin
		state_d      = state_q;
		done_d       = 1'b0;
		fired_d      = fired_q;
		hole_d       = hole_q;
		cnt_d        = cnt_q;
		mv_d         = mv_q;
		best_d       = best_q;
		best_child_d = best_child_q;
		now_d        = now_q;
		task_d       = task_q;
		wr_en        = 1'b0;
		wr_data      = mv_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.start) begin
					fired_d = 1'b0;
					if (cmd.pop) begin
						now_d   = now_time;
						cnt_d   = cmd_count;
						state_d = S_POP_ROOT;
					end else begin
						mv_d    = {new_deadline, new_seq, new_task};
						hole_d  = cmd_count[AW-1:0];
						state_d = S_UP_CHK;
					end
				end
			end
			S_UP_CHK: begin
				if (hole_q == '0) begin
					wr_en   = 1'b1;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (lt) begin
					wr_data = rd_data_q;
					hole_d  = parent;
					state_d = S_UP_CHK;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_POP_ROOT: begin
				if (lt) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					fired_d = 1'b1;
					task_d  = rd_data_q[TASK_BITS-1:0];
					cnt_d   = last_i;
					if (last_i == '0) begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_POP_LAST;
					end
				end
			end
			S_POP_LAST: begin
				mv_d    = rd_data_q;
				hole_d  = '0;
				state_d = S_DN_L;
			end
			S_DN_L: begin
				if (left_i >= cnt_ext) begin
					wr_en   = 1'b1;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_DN_R;
				end
			end
			S_DN_R: begin
				if (right_i < cnt_ext) begin
					best_d       = lt ? rd_data_q : mv_q;
					best_child_d = lt;
					state_d      = S_DN_C;
				end else if (lt) begin
					wr_en   = 1'b1;
					wr_data = rd_data_q;
					hole_d  = left_i[AW-1:0];
					state_d = S_DN_L;
				end else begin
					wr_en   = 1'b1;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_DN_C: begin
				wr_en = 1'b1;
				if (lt) begin
					wr_data = rd_data_q;
					hole_d  = right_i[AW-1:0];
					state_d = S_DN_L;
				end else if (best_child_q) begin
					wr_data = best_q;
					hole_d  = left_i[AW-1:0];
					state_d = S_DN_L;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			fired_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			fired_q <= fired_d;
		end
	end

	// Working registers of the sift.
	always_ff @(posedge clk) begin
		hole_q       <= hole_d;
		cnt_q        <= cnt_d;
		mv_q         <= mv_d;
		best_q       <= best_d;
		best_child_q <= best_child_d;
		now_q        <= now_d;
		task_q       <= task_d;
	end

	assign resp.done  = done_q;
	assign resp.fired = fired_q;
	assign resp_task  = task_q;

endmodule

// ===== hw/rtl/deadline_timer_task_queue.sv =====
// Top level of the deadline timer task queue: front end, time keeping and result register.
//
// Usage: each input transaction is either an add (task_id, signed delay) or one
// time tick. Every input transaction yields exactly one result transaction with
// status, fired_task and pending. Both channels use valid and stall; a
// transaction moves on a clock edge with valid high and stall low.
// The block works on one transaction at a time. in_stall is high from the
// cycle after acceptance until the result has been placed in the output
// register. An entry moves at most log2 of QUEUE_DEPTH heap levels. The heap
// memory has one read and one write port; each level of an insert is one read
// and one use of the shared key comparator, and each level of a pop is up to
// two reads and two compares. A full queue or a tick on an empty queue goes
// from the preparation state straight to the result without a heap command.
// The next transaction is accepted at the earliest in the cycle after the
// result is loaded. The output register holds a finished result while out_stall
// is high; the next input transaction is still taken and runs, and its result
// waits until the register is free. Reset clears the time, the sequence counter,
// the task count and the output valid flag; no clearing pass over the heap is
// needed.
module deadline_timer_task_queue import dttq_pkg::*; #(
	parameter int QUEUE_DEPTH  = QueueDepthDef,
	parameter int TASK_ID_BITS = TaskIdBitsDef,
	parameter int TIME_BITS    = TimeBitsDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic [TaskFieldBits-1:0]        task_id,
	input  logic signed [DelayBits-1:0]     delay,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [StatusBits-1:0]           status,
	output logic [TaskFieldBits-1:0]        fired_task,
	output logic [PendingBits-1:0]          pending
);

	localparam int TaskW = (TASK_ID_BITS < TaskFieldBits) ? TASK_ID_BITS : TaskFieldBits;
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam logic [TIME_BITS-1:0] TimeMax = '1;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_PREP = 2'd1;
	localparam logic [1:0] F_WAIT = 2'd2;
	localparam logic [1:0] F_OUT  = 2'd3;

	logic [1:0]            state_q;
	logic                  op_q;
	logic [TaskW-1:0]      task_q;
	logic [DelayBits-1:0]  delay_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [SeqBits-1:0]    seq_q;
	logic [CW-1:0]         count_q;
	logic [StatusBits-1:0] res_status_q;
	logic [TaskW-1:0]      res_fired_q;
	logic                  out_valid_q;
	logic [StatusBits-1:0] status_q;
	logic [TaskFieldBits-1:0] fired_q;
	logic [PendingBits-1:0]   pending_q;

	logic [TIME_BITS-1:0]  dly_pos;
	logic [TIME_BITS:0]    dl_sum;
	logic [TIME_BITS-1:0]  deadline;
	logic [TIME_BITS-1:0]  now_next;
	logic                  is_full;
	logic                  is_empty;
	logic                  out_free;
	logic [CW+PendingBits-1:0]   pend_ext;
	logic [TaskW+TaskFieldBits-1:0] fired_ext;

	dttq_cmd_t             cmd;
	dttq_resp_t            resp;
	logic [TaskW-1:0]      resp_task;

	// Deadline with a negative delay clamped to zero and saturation at the time limit.
	assign dly_pos  = delay_q[DelayBits-1] ? '0 : TIME_BITS'(delay_q[DelayBits-2:0]);
	assign dl_sum   = {1'b0, now_q} + {1'b0, dly_pos};
	assign deadline = dl_sum[TIME_BITS] ? TimeMax : dl_sum[TIME_BITS-1:0];

	// Saturating time advance for a tick.
	assign now_next = (now_q == TimeMax) ? now_q : now_q + TIME_BITS'(1);

	assign is_full  = (count_q == CW'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);
	assign out_free = !out_valid_q || !out_stall;

	assign pend_ext  = {{PendingBits{1'b0}}, count_q};
	assign fired_ext = {{TaskFieldBits{1'b0}}, res_fired_q};

	// Heap command issued from the preparation cycle.
	assign cmd.start = (state_q == F_PREP) && ((op_q == OP_TICK) ? !is_empty : !is_full);
	assign cmd.pop   = (op_q == OP_TICK);

	dttq_heap #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TASK_BITS   (TaskW),
		.TIME_BITS   (TIME_BITS)
	) u_heap (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cmd_count    (count_q),
		.new_deadline (deadline),
		.new_seq      (seq_q),
		.new_task     (task_q),
		.now_time     (now_next),
		.resp         (resp),
		.resp_task    (resp_task)
	);

	// Front-end sequencer, time, sequence number and task count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			now_q       <= '0;
			seq_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != F_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_PREP;
					end
				end
				F_PREP: begin
					if (op_q == OP_TICK) begin
						now_q   <= now_next;
						state_q <= is_empty ? F_OUT : F_WAIT;
					end else if (is_full) begin
						state_q <= F_OUT;
					end else begin
						seq_q   <= seq_q + SeqBits'(1);
						count_q <= count_q + CW'(1);
						state_q <= F_WAIT;
					end
				end
				F_WAIT: begin
					if (resp.done) begin
						if (resp.fired) begin
							count_q <= count_q - CW'(1);
						end
						state_q <= F_OUT;
					end
				end
				F_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Captured transaction, pending result and output payload.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			op_q    <= opcode;
			task_q  <= task_id[TaskW-1:0];
			delay_q <= delay;
		end
		if (state_q == F_PREP) begin
			res_fired_q <= '0;
			if (op_q == OP_TICK) begin
				res_status_q <= STATUS_NONE;
			end else if (is_full) begin
				res_status_q <= STATUS_FULL;
			end else begin
				res_status_q <= STATUS_ADDED;
			end
		end
		if (state_q == F_WAIT && resp.done && resp.fired) begin
			res_status_q <= STATUS_FIRED;
			res_fired_q  <= resp_task;
		end
		if (state_q == F_OUT && out_free) begin
			status_q  <= res_status_q;
			fired_q   <= fired_ext[TaskFieldBits-1:0];
			pending_q <= pend_ext[PendingBits-1:0];
		end
	end

	assign in_stall   = (state_q != F_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign fired_task = fired_q;
	assign pending    = pending_q;

endmodule
